FILE: design/tsr_pkg.sv
`default_nettype none
package tsr_pkg;

   localparam int COORD_BITS = 12;
   localparam int DIFF_BITS  = COORD_BITS + 1;   // vertex deltas, major, minor, step count
   localparam int ERR_BITS   = COORD_BITS + 2;   // error term, holds error + minor
   localparam int X_BITS     = COORD_BITS + 4;   // edge x with room to overshoot
   localparam int ROW_BITS   = COORD_BITS + 1;   // row may pass the bottom vertex by one

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_NEXT = 1'b1;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_UPPER = 2'd1,
      PHASE_LOWER = 2'd2
   } phase_type;

   typedef struct packed {
      logic                         opcode;
      logic signed [COORD_BITS-1:0] vert_a_x;
      logic signed [COORD_BITS-1:0] vert_a_y;
      logic signed [COORD_BITS-1:0] vert_b_x;
      logic signed [COORD_BITS-1:0] vert_b_y;
      logic signed [COORD_BITS-1:0] vert_c_x;
      logic signed [COORD_BITS-1:0] vert_c_y;
      logic [7:0]                   fill_color;
      logic [7:0]                   fill_brightness;
   } req_type;

   typedef struct packed {
      logic                         span_valid;
      logic signed [COORD_BITS-1:0] span_start;
      logic signed [COORD_BITS-1:0] span_end;
      logic signed [COORD_BITS-1:0] span_row;
      logic [7:0]                   span_color;
      logic [7:0]                   span_brightness;
      logic                         last_span;
   } rsp_type;

   // operands of one error step
   typedef struct packed {
      logic [ERR_BITS-1:0]  error;
      logic [DIFF_BITS-1:0] major;
      logic [DIFF_BITS-1:0] minor;
      logic                 steep;
   } step_op_type;

   // outcome of one error step
   typedef struct packed {
      logic [ERR_BITS-1:0] error;
      logic                nudge;   // steep edge moves one pixel this row
      logic                stop;    // row is done for this edge
   } step_res_type;

   typedef struct packed {
      logic [DIFF_BITS-1:0] major;
      logic [DIFF_BITS-1:0] minor;
      logic [ERR_BITS-1:0]  error;
      logic                 neg;
      logic                 steep;
   } edge_setup_type;

   function automatic edge_setup_type setup_edge(
      input logic signed [COORD_BITS-1:0] x0,
      input logic signed [COORD_BITS-1:0] y0,
      input logic signed [COORD_BITS-1:0] x1,
      input logic signed [COORD_BITS-1:0] y1);
      logic signed [DIFF_BITS-1:0] d;
      logic signed [DIFF_BITS-1:0] h;
      logic [DIFF_BITS-1:0]        ad;
      edge_setup_type              s;
      d  = DIFF_BITS'(x1) - DIFF_BITS'(x0);
      h  = DIFF_BITS'(y1) - DIFF_BITS'(y0);
      ad = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
      s.neg = d[DIFF_BITS-1];
      if (h > $signed(ad)) begin
         s.major = DIFF_BITS'(h);
         s.minor = ad;
         s.steep = 1'b1;
      end else begin
         s.major = ad;
         s.minor = DIFF_BITS'(h);
         s.steep = 1'b0;
      end
      s.error = ERR_BITS'(s.major >> 1);
      return s;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [X_BITS-1:0] v);
      logic signed [X_BITS-1:0] cmax;
      logic signed [X_BITS-1:0] cmin;
      cmax = X_BITS'((1 << (COORD_BITS - 1)) - 1);
      cmin = -cmax - X_BITS'(1);
      if (v > cmax) return cmax[COORD_BITS-1:0];
      if (v < cmin) return cmin[COORD_BITS-1:0];
      return v[COORD_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: design/tsr_edge_unit.sv
`default_nettype none
module tsr_edge_unit
   import tsr_pkg::*;
(
   input  step_op_type  op,
   output step_res_type res
);

   logic [ERR_BITS-1:0] sum;
   logic                wrap;

   // one Bresenham step: add minor, fold back by major once
   always_comb begin
      sum       = op.error + ERR_BITS'(op.minor);
      wrap      = (sum >= ERR_BITS'(op.major));
      res.error = wrap ? sum - ERR_BITS'(op.major) : sum;
      res.nudge = wrap & op.steep;
      res.stop  = wrap | op.steep;
   end

endmodule
`default_nettype wire

FILE: design/triangle_span_rasterizer.sv
`default_nettype none
// Triangle span rasterizer.
// req channel: one beat is either a load (opcode 0: three vertices, color,
// brightness) or a next-span request (opcode 1). A load gives no rsp beat;
// each request gives exactly one rsp beat. After the last span of a
// triangle (last_span set), or before any load, a request returns a beat
// with span_valid low and all other fields zero.
// Sequence: a load runs the long-edge and the short-edge setup states before
// req_ready returns (a flat top adds the lower-edge setup state). A span
// request runs the short-edge state, the long-edge state and the finish
// state before rsp_valid; each edge state does one error step per cycle
// through the single shared step unit until that edge is done for the row. A
// span that ends the upper half passes through the lower-edge setup state
// after the beat is posted.
// The block takes one beat at a time: req_ready is high only while the
// sequencer idles and no rsp beat is held. A stalled rsp_ready holds the
// result register and thereby the req side.
// Reset (synchronous) drops any triangle: the fill phase goes idle and the
// edge state clears.
module triangle_span_rasterizer
   import tsr_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  wire     rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [6:0] {
      S_IDLE        = 7'b0000001,
      S_SETUP_LONG  = 7'b0000010,
      S_SETUP_SHORT = 7'b0000100,
      S_SETUP_LOWER = 7'b0001000,
      S_SHORT       = 7'b0010000,
      S_LONG        = 7'b0100000,
      S_FINISH      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   // sorted vertices: index 0 top, 1 middle, 2 bottom
   logic signed [COORD_BITS-1:0] vx_ff [3];
   logic signed [COORD_BITS-1:0] vx_in [3];
   logic signed [COORD_BITS-1:0] vy_ff [3];
   logic signed [COORD_BITS-1:0] vy_in [3];

   // edge 0 short, edge 1 long
   logic signed [X_BITS-1:0] x_ff     [2];
   logic signed [X_BITS-1:0] x_in     [2];
   logic [ERR_BITS-1:0]      err_ff   [2];
   logic [ERR_BITS-1:0]      err_in   [2];
   logic [DIFF_BITS-1:0]     major_ff [2];
   logic [DIFF_BITS-1:0]     major_in [2];
   logic [DIFF_BITS-1:0]     minor_ff [2];
   logic [DIFF_BITS-1:0]     minor_in [2];
   logic                     neg_ff   [2];
   logic                     neg_in   [2];
   logic                     steep_ff [2];
   logic                     steep_in [2];
   logic                     nudge_ff [2];
   logic                     nudge_in [2];
   logic signed [X_BITS-1:0] pre_ff   [2];
   logic signed [X_BITS-1:0] pre_in   [2];

   logic signed [ROW_BITS-1:0] row_ff, row_in;
   logic [DIFF_BITS-1:0]       step_ff, step_in;
   logic [7:0]                 color_ff, color_in;
   logic [7:0]                 bright_ff, bright_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   step_op_type  unit_op;
   step_res_type unit_res;
   logic         sel;

   tsr_edge_unit u_step (
      .op  (unit_op),
      .res (unit_res)
   );

   // the shared step unit serves the short edge, then the long edge
   always_comb begin
      sel           = (state_ff == S_LONG);
      unit_op.error = err_ff[sel];
      unit_op.major = major_ff[sel];
      unit_op.minor = minor_ff[sel];
      unit_op.steep = steep_ff[sel];
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   function automatic logic signed [X_BITS-1:0] unit_x(input logic neg);
      return neg ? -X_BITS'(1) : X_BITS'(1);
   endfunction

   logic signed [COORD_BITS-1:0] sx [3];
   logic signed [COORD_BITS-1:0] sy [3];
   logic signed [COORD_BITS-1:0] tmp;
   edge_setup_type               es;
   logic signed [X_BITS-1:0]     lo, hi, ex0, ex1;
   logic signed [ROW_BITS-1:0]   row_next;
   logic [DIFF_BITS-1:0]         step_next;
   logic                         last;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      x_in         = x_ff;
      err_in       = err_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      neg_in       = neg_ff;
      steep_in     = steep_ff;
      nudge_in     = nudge_ff;
      pre_in       = pre_ff;
      row_in       = row_ff;
      step_in      = step_ff;
      color_in     = color_ff;
      bright_in    = bright_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      sx[0] = req_data.vert_a_x; sy[0] = req_data.vert_a_y;
      sx[1] = req_data.vert_b_x; sy[1] = req_data.vert_b_y;
      sx[2] = req_data.vert_c_x; sy[2] = req_data.vert_c_y;
      tmp       = '0;
      es        = '0;
      lo        = '0;
      hi        = '0;
      ex0       = '0;
      ex1       = '0;
      row_next  = row_ff + ROW_BITS'(1);
      step_next = step_ff + DIFF_BITS'(1);
      last      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_data.opcode == OP_LOAD) begin
                  // sort by y: swap a/b, a/c, b/c on strictly greater
                  if (sy[0] > sy[1]) begin
                     tmp = sx[0]; sx[0] = sx[1]; sx[1] = tmp;
                     tmp = sy[0]; sy[0] = sy[1]; sy[1] = tmp;
                  end
                  if (sy[0] > sy[2]) begin
                     tmp = sx[0]; sx[0] = sx[2]; sx[2] = tmp;
                     tmp = sy[0]; sy[0] = sy[2]; sy[2] = tmp;
                  end
                  if (sy[1] > sy[2]) begin
                     tmp = sx[1]; sx[1] = sx[2]; sx[2] = tmp;
                     tmp = sy[1]; sy[1] = sy[2]; sy[2] = tmp;
                  end
                  vx_in     = sx;
                  vy_in     = sy;
                  color_in  = req_data.fill_color;
                  bright_in = req_data.fill_brightness;
                  phase_in  = PHASE_IDLE;
                  state_in  = S_SETUP_LONG;
               end else if (phase_ff == PHASE_IDLE) begin
                  rsp_in       = '0;
                  rsp_valid_in = 1'b1;
               end else begin
                  pre_in   = x_ff;
                  nudge_in = '{1'b0, 1'b0};
                  state_in = S_SHORT;
               end
            end
         end
         S_SETUP_LONG: begin
            es          = setup_edge(vx_ff[0], vy_ff[0], vx_ff[2], vy_ff[2]);
            major_in[1] = es.major;
            minor_in[1] = es.minor;
            err_in[1]   = es.error;
            neg_in[1]   = es.neg;
            steep_in[1] = es.steep;
            x_in[0]     = X_BITS'(vx_ff[0]);
            x_in[1]     = X_BITS'(vx_ff[0]);
            row_in      = ROW_BITS'(vy_ff[0]);
            state_in    = S_SETUP_SHORT;
         end
         S_SETUP_SHORT: begin
            if (vy_ff[0] == vy_ff[1]) begin
               // flat top: skip the upper half
               state_in = S_SETUP_LOWER;
            end else begin
               es          = setup_edge(vx_ff[0], vy_ff[0], vx_ff[1], vy_ff[1]);
               major_in[0] = es.major;
               minor_in[0] = es.minor;
               err_in[0]   = es.error;
               neg_in[0]   = es.neg;
               steep_in[0] = es.steep;
               step_in     = '0;
               phase_in    = PHASE_UPPER;
               state_in    = S_IDLE;
            end
         end
         S_SETUP_LOWER: begin
            es          = setup_edge(vx_ff[1], vy_ff[1], vx_ff[2], vy_ff[2]);
            major_in[0] = es.major;
            minor_in[0] = es.minor;
            err_in[0]   = es.error;
            neg_in[0]   = es.neg;
            steep_in[0] = es.steep;
            x_in[0]     = X_BITS'(vx_ff[1]);
            step_in     = '0;
            phase_in    = PHASE_LOWER;
            state_in    = S_IDLE;
         end
         S_SHORT: begin
            if (step_ff < major_ff[0]) begin
               err_in[0] = unit_res.error;
               if (unit_res.nudge) nudge_in[0] = 1'b1;
               // upper half counts the step before it, lower half after a move
               if (phase_ff == PHASE_UPPER) step_in = step_next;
               if (unit_res.stop) begin
                  state_in = S_LONG;
               end else begin
                  x_in[0] = x_ff[0] + unit_x(neg_ff[0]);
                  if (phase_ff == PHASE_LOWER) step_in = step_next;
               end
            end else begin
               state_in = S_LONG;
            end
         end
         S_LONG: begin
            // lower half stops the long edge at the bottom vertex
            if (phase_ff == PHASE_LOWER && x_ff[1] == X_BITS'(vx_ff[2])) begin
               state_in = S_FINISH;
            end else begin
               err_in[1] = unit_res.error;
               if (unit_res.nudge) nudge_in[1] = 1'b1;
               if (unit_res.stop) state_in = S_FINISH;
               else x_in[1] = x_ff[1] + unit_x(neg_ff[1]);
            end
         end
         S_FINISH: begin
            lo = (pre_ff[0] < pre_ff[1]) ? pre_ff[0] : pre_ff[1];
            hi = (pre_ff[0] < pre_ff[1]) ? pre_ff[1] : pre_ff[0];
            if (lo > x_ff[0]) lo = x_ff[0];
            if (lo > x_ff[1]) lo = x_ff[1];
            if (hi < x_ff[0]) hi = x_ff[0];
            if (hi < x_ff[1]) hi = x_ff[1];
            ex0 = (!steep_ff[0] || nudge_ff[0]) ? x_ff[0] + unit_x(neg_ff[0]) : x_ff[0];
            ex1 = (!steep_ff[1] || nudge_ff[1]) ? x_ff[1] + unit_x(neg_ff[1]) : x_ff[1];
            x_in[0]  = ex0;
            x_in[1]  = ex1;
            row_in   = row_next;
            state_in = S_IDLE;
            if (phase_ff == PHASE_UPPER) begin
               if (row_next == ROW_BITS'(vy_ff[1]) || step_ff >= major_ff[0])
                  state_in = S_SETUP_LOWER;
            end else if (row_next > ROW_BITS'(vy_ff[2])) begin
               last = 1'b1;
            end else begin
               step_in = step_next;
               if (step_next > major_ff[0]) last = 1'b1;
            end
            if (last) phase_in = PHASE_IDLE;
            rsp_in.span_valid      = 1'b1;
            rsp_in.span_start      = sat_coord(lo);
            rsp_in.span_end        = sat_coord(hi);
            rsp_in.span_row        = sat_coord(X_BITS'(row_ff));
            rsp_in.span_color      = color_ff;
            rsp_in.span_brightness = bright_ff;
            rsp_in.last_span       = last;
            rsp_valid_in           = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PHASE_IDLE;
         rsp_valid_ff <= 1'b0;
         vx_ff        <= '{default: '0};
         vy_ff        <= '{default: '0};
         x_ff         <= '{default: '0};
         err_ff       <= '{default: '0};
         major_ff     <= '{default: '0};
         minor_ff     <= '{default: '0};
         neg_ff       <= '{default: 1'b0};
         steep_ff     <= '{default: 1'b0};
         row_ff       <= '0;
         step_ff      <= '0;
         color_ff     <= '0;
         bright_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         vx_ff        <= vx_in;
         vy_ff        <= vy_in;
         x_ff         <= x_in;
         err_ff       <= err_in;
         major_ff     <= major_in;
         minor_ff     <= minor_in;
         neg_ff       <= neg_in;
         steep_ff     <= steep_in;
         row_ff       <= row_in;
         step_ff      <= step_in;
         color_ff     <= color_in;
         bright_ff    <= bright_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      nudge_ff <= nudge_in;
      pre_ff   <= pre_in;
      rsp_ff   <= rsp_in;
   end

   // an idle-phase request answers at once with an empty beat
   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.opcode == OP_NEXT && phase_ff == PHASE_IDLE)
      |=> (rsp_valid && !rsp_data.span_valid))
      else $error("idle request did not return an empty beat");

   // edge stepping never runs while a result is held
   a_no_step_while_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHORT || state_ff == S_LONG) |-> !rsp_valid_ff)
      else $error("edge stepping with a result pending");

   // the short edge step count stays within its major length
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHORT) |-> (step_ff <= major_ff[0]))
      else $error("short edge step count beyond major length");

   // a span beat is posted only out of the finish step
   a_span_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_ff.span_valid) |-> ($past(state_ff) == S_FINISH))
      else $error("span beat posted outside the finish step");

endmodule
`default_nettype wire

FILE: bench/span_checker.sv
`timescale 1ns / 100ps
module span_checker
   import tsr_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   input  wire     req_ready,
   input  req_type req_data,
   input  wire     rsp_valid,
   input  wire     rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding
);

   localparam int CMAX = (1 << (COORD_BITS - 1)) - 1;
   localparam int CMIN = -(1 << (COORD_BITS - 1));
   localparam int DUE_DEPTH = 16;

   // triangle state: top, middle, bottom as x/y pairs; edge 0 short, edge 1 long
   int        vtx[6];
   int        ex[2], eerr[2], emaj[2], emin[2], esgn[2];
   bit        esteep[2];
   int        row_now, steps;
   phase_type phase;
   logic [7:0] color_q, bright_q;

   // expected beats in order of arrival
   rsp_type   due_q[DUE_DEPTH];
   int        due_wr = 0;
   int        due_rd = 0;
   int        due_count = 0;

   function automatic void clear_state();
      foreach (vtx[k]) vtx[k] = 0;
      for (int k = 0; k < 2; k++) begin
         ex[k] = 0; eerr[k] = 0; emaj[k] = 0; emin[k] = 0; esgn[k] = 0;
         esteep[k] = 0;
      end
      row_now = 0;
      steps = 0;
      phase = PHASE_IDLE;
      color_q = '0;
      bright_q = '0;
   endfunction

   function automatic void edge_init(int k, int x0, int y0, int x1, int y1);
      int d, h;
      d = x1 - x0;
      h = y1 - y0;
      esgn[k] = (d < 0) ? -1 : 1;
      if (d < 0) d = -d;
      if (h > d) begin
         emaj[k] = h; emin[k] = d; esteep[k] = 1;
      end else begin
         emaj[k] = d; emin[k] = h; esteep[k] = 0;
      end
      eerr[k] = emaj[k] / 2;
   endfunction

   function automatic void enter_lower();
      edge_init(0, vtx[2], vtx[3], vtx[4], vtx[5]);
      ex[0] = vtx[2];
      steps = 0;
      phase = PHASE_LOWER;
   endfunction

   function automatic void swap_pair(int p, int q);
      int t;
      t = vtx[p]; vtx[p] = vtx[q]; vtx[q] = t;
      t = vtx[p+1]; vtx[p+1] = vtx[q+1]; vtx[q+1] = t;
   endfunction

   // step the long edge until its row is done; return the steep nudge
   function automatic int long_walk(bit guard);
      int  nudge;
      bit  hop;
      nudge = 0;
      while (!guard || ex[1] != vtx[4]) begin
         hop = 0;
         eerr[1] += emin[1];
         while (eerr[1] >= emaj[1]) begin
            eerr[1] -= emaj[1];
            if (esteep[1]) nudge = esgn[1];
            else begin
               hop = 1;
               break;
            end
         end
         if (hop || esteep[1]) break;
         ex[1] += esgn[1];
      end
      return nudge;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] clamp(int v);
      if (v > CMAX) v = CMAX;
      if (v < CMIN) v = CMIN;
      return v[COORD_BITS-1:0];
   endfunction

   // returns 1 when the beat yields a rsp beat (a span or an empty idle answer)
   function automatic bit next_span(req_type r, output rsp_type s);
      int  pre0, pre1, lo, hi, n0, n1, rw;
      bit  hop, last;
      s = '0;
      n0 = 0;
      last = 0;
      if (r.opcode == OP_LOAD) begin
         vtx[0] = r.vert_a_x; vtx[1] = r.vert_a_y;
         vtx[2] = r.vert_b_x; vtx[3] = r.vert_b_y;
         vtx[4] = r.vert_c_x; vtx[5] = r.vert_c_y;
         color_q = r.fill_color;
         bright_q = r.fill_brightness;
         if (vtx[1] > vtx[3]) swap_pair(0, 2);
         if (vtx[1] > vtx[5]) swap_pair(0, 4);
         if (vtx[3] > vtx[5]) swap_pair(2, 4);
         edge_init(1, vtx[0], vtx[1], vtx[4], vtx[5]);
         ex[0] = vtx[0];
         ex[1] = vtx[0];
         row_now = vtx[1];
         if (vtx[1] == vtx[3]) enter_lower();
         else begin
            edge_init(0, vtx[0], vtx[1], vtx[2], vtx[3]);
            steps = 0;
            phase = PHASE_UPPER;
         end
         return 0;
      end
      if (phase == PHASE_IDLE) return 1;

      pre0 = ex[0];
      pre1 = ex[1];
      if (phase == PHASE_UPPER) begin
         while (steps < emaj[0]) begin
            hop = 0;
            steps++;
            eerr[0] += emin[0];
            while (eerr[0] >= emaj[0]) begin
               eerr[0] -= emaj[0];
               if (esteep[0]) n0 = esgn[0];
               else begin
                  hop = 1;
                  break;
               end
            end
            if (hop || esteep[0]) break;
            ex[0] += esgn[0];
         end
         n1 = long_walk(0);
      end else begin
         while (steps < emaj[0]) begin
            hop = 0;
            eerr[0] += emin[0];
            if (eerr[0] >= emaj[0]) begin
               eerr[0] -= emaj[0];
               if (esteep[0]) n0 = esgn[0];
               else hop = 1;
            end
            if (hop || esteep[0]) break;
            ex[0] += esgn[0];
            steps++;
         end
         n1 = long_walk(1);
      end

      lo = (pre0 < pre1) ? pre0 : pre1;
      hi = (pre0 < pre1) ? pre1 : pre0;
      if (lo > ex[0]) lo = ex[0];
      if (lo > ex[1]) lo = ex[1];
      if (hi < ex[0]) hi = ex[0];
      if (hi < ex[1]) hi = ex[1];
      rw = row_now;

      if (!esteep[0]) ex[0] += esgn[0];
      ex[0] += n0;
      if (!esteep[1]) ex[1] += esgn[1];
      ex[1] += n1;
      row_now++;

      if (phase == PHASE_UPPER) begin
         if (row_now == vtx[3] || steps >= emaj[0]) enter_lower();
      end else if (row_now > vtx[5]) begin
         last = 1;
      end else begin
         steps++;
         if (steps > emaj[0]) last = 1;
      end
      if (last) phase = PHASE_IDLE;

      s.span_valid = 1'b1;
      s.span_start = clamp(lo);
      s.span_end = clamp(hi);
      s.span_row = clamp(rw);
      s.span_color = color_q;
      s.span_brightness = bright_q;
      s.last_span = last;
      return 1;
   endfunction

   assign outstanding = due_count;

   always @(posedge clock) begin
      rsp_type want, got;
      if (reset) begin
         clear_state();
         due_wr = 0;
         due_rd = 0;
         due_count = 0;
         mismatches <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (next_span(req_data, want)) begin
               due_q[due_wr] = want;
               due_wr = (due_wr + 1) % DUE_DEPTH;
               due_count++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (due_count == 0) begin
               if (mismatches < 10) $display("%0t: span beat with none due: %p", $time, got);
               mismatches <= mismatches + 1;
            end else begin
               want = due_q[due_rd];
               due_rd = (due_rd + 1) % DUE_DEPTH;
               due_count--;
               if (got.span_valid !== want.span_valid || got.span_start !== want.span_start ||
                   got.span_end !== want.span_end || got.span_row !== want.span_row ||
                   got.span_color !== want.span_color ||
                   got.span_brightness !== want.span_brightness ||
                   got.last_span !== want.last_span) begin
                  if (mismatches < 10)
                     $display("%0t: span mismatch, due %p, seen %p", $time, want, got);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

FILE: bench/triangle_span_rasterizer_tb.sv
`timescale 1ns / 100ps
module triangle_span_rasterizer_tb;
   import tsr_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      mismatches;
   int      outstanding;

   int      beats_sent = 0;
   bit      quiet = 0;     // last part of the run: no idling on either side

   always #5 clock = ~clock;

   triangle_span_rasterizer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   span_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Receiver: short random stall bursts, plus one long hold-off that lets the
   // block fill up and push back on the request side.
   initial begin
      int stall_left;
      bit long_done;
      stall_left = 0;
      long_done = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!long_done && beats_sent >= 150) begin
            stall_left = 400;
            long_done = 1;
         end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Drive one beat and hold it until the block takes it. Ready is looked at on
   // the falling edge, so the acceptance edge is the next rising one.
   task automatic send_beat(req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
      beats_sent++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   function automatic req_type noise_beat(logic op);
      req_type     r;
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      r.opcode = op;
      return r;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] fit(int v);
      if (v > 2047) v = 2047;
      if (v < -2048) v = -2048;
      return v[COORD_BITS-1:0];
   endfunction

   // Load a triangle, then ask for spans: enough to run past the last one unless
   // cut short, so the idle answer and a reload mid-fill both get exercised.
   task automatic fill_triangle(int ax, int ay, int bx, int by, int cx, int cy,
                                logic [7:0] col, logic [7:0] bri, bit cut);
      req_type r;
      int lo, hi, n;
      r = noise_beat(OP_LOAD);
      r.vert_a_x = fit(ax); r.vert_a_y = fit(ay);
      r.vert_b_x = fit(bx); r.vert_b_y = fit(by);
      r.vert_c_x = fit(cx); r.vert_c_y = fit(cy);
      r.fill_color = col;
      r.fill_brightness = bri;
      send_beat(r);
      lo = r.vert_a_y; hi = r.vert_a_y;
      if (r.vert_b_y < lo) lo = r.vert_b_y;
      if (r.vert_c_y < lo) lo = r.vert_c_y;
      if (r.vert_b_y > hi) hi = r.vert_b_y;
      if (r.vert_c_y > hi) hi = r.vert_c_y;
      n = hi - lo + 2;
      if (cut) n = $urandom_range(0, n - 1);
      repeat (n) send_beat(noise_beat(OP_NEXT));
   endtask

   task automatic random_triangle();
      int bx, by, w, hgt;
      bx = $signed($urandom_range(0, 4095) - 2048);
      by = $signed($urandom_range(0, 4095) - 2048);
      w = ($urandom_range(0, 9) == 0) ? 300 : 40;
      hgt = $urandom_range(0, 12);
      fill_triangle(bx + $urandom_range(0, w) - w / 2, by + $urandom_range(0, hgt),
                    bx + $urandom_range(0, w) - w / 2, by + $urandom_range(0, hgt),
                    bx + $urandom_range(0, w) - w / 2, by + $urandom_range(0, hgt),
                    8'($urandom), 8'($urandom), $urandom_range(0, 7) == 0);
   endtask

   initial begin
      int tri_count;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle request, extremes of every field, flat top, degenerate
      send_beat(noise_beat(OP_NEXT));
      fill_triangle(-2048, -2048, 2047, -2047, 0, -2046, 8'd0, 8'd255, 0);
      fill_triangle(5, 2045, -3, 2047, 9, 2047, 8'd255, 8'd0, 0);
      fill_triangle(0, 10, 8, 10, 4, 14, 8'h5a, 8'ha5, 0);
      fill_triangle(7, 7, 7, 7, 7, 7, 8'h11, 8'h22, 0);
      fill_triangle(0, 0, 3, 3, 6, 6, 8'h33, 8'h44, 0);
      fill_triangle(20, -5, 1, 4, 30, 3, 8'h77, 8'h88, 0);
      fill_triangle(2047, 100, -2048, 100, 0, 100, 8'h99, 8'h66, 0);

      // random: mostly well-formed fills, some cut short, some stray beats
      tri_count = 0;
      while (beats_sent < 450) begin
         if (beats_sent > 400) quiet = 1;
         if ($urandom_range(0, 15) == 0) send_beat(noise_beat(1'($urandom_range(0, 1))));
         else random_triangle();
         tri_count++;
         if (tri_count == 20) begin
            // drain completely before going on
            req_valid <= 1'b0;
            wait (outstanding == 0);
            @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule
